@@ sv/circular_scan_crossfade_mixer_core_macros.svh @@
// Assertion macros shared by the mixer core RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef CIRCULAR_SCAN_CROSSFADE_MIXER_CORE_MACROS_SVH
`define CIRCULAR_SCAN_CROSSFADE_MIXER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CSXFM_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CSXFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSXFM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSXFM_ASSERT(lbl, clk, rst_n, cond, msg)
`define CSXFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CSXFM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/csxfm_pkg.sv @@
// Shared types and constants of the scanning crossfade mixer core.
// No dependencies.
`timescale 1ns / 1ps

package csxfm_pkg;

    localparam int CHANNELS_DEFAULT = 12;
    localparam int MASK_BITS        = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SELECTION_OFFSET = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CV_AMOUNT        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_DIFFUSION    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONLY_CONNECTED   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CONNECTED_MASK   = 3'd4;

    localparam logic signed [11:0] OFFSET_RESET = 12'sd0;
    localparam logic signed [15:0] AMOUNT_RESET = 16'sd0;
    localparam logic [14:0]        INV_RESET    = 15'd10923;
    localparam logic               OC_RESET     = 1'b0;
    localparam logic [11:0]        MASK_RESET   = 12'hFFF;

    // scan center, six channels in Q8
    localparam logic signed [14:0] POS_BASE  = 15'sd1536;
    localparam logic [12:0]        SCAN_MAX  = 13'd4096;
    localparam logic [15:0]        LEVEL_ONE = 16'd32768;

    localparam logic signed [21:0] ACC_MAX = 22'sd1048575;
    localparam logic signed [21:0] ACC_MIN = -22'sd1048576;

    typedef struct packed {
        logic load_in;
        logic cv_mul;
        logic latch_pos;
        logic wrap_step;
        logic dist_calc;
        logic scale;
        logic term;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic first_channel;
        logic wrap_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/circular_scan_crossfade_mixer_core.sv @@
// Scanning crossfade mixer core. Channel beats of a frame arrive in order; each returns its
// crossfade level and the final beat also returns the saturated weighted frame sum. A beat
// for channels 1 and up passes the distance, scale, term and emit states; the beat that
// opens a frame first passes the cv multiply, position latch and wrap states, where the
// one-step wrap adder of the datapath adds or subtracts the span until the position lies
// in range. Emit waits while a result is still held and stalled. A result waits in an
// output register, so the next beat is taken while it is still held.
`timescale 1ns / 1ps

module circular_scan_crossfade_mixer_core #(
    parameter int CHANNELS = csxfm_pkg::CHANNELS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [csxfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [csxfm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [15:0]                channel_sample,
    input  logic [9:0]                        channel_gain,
    input  logic signed [12:0]                control_cv,
    input  logic                              last_channel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [15:0]                       channel_level,
    output logic signed [20:0]                mix_sum,
    output logic                              mix_valid
);

    csxfm_pkg::dp_cmd_t    cmd;
    csxfm_pkg::dp_status_t status;

    csxfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    csxfm_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .channel_sample (channel_sample),
        .channel_gain   (channel_gain),
        .control_cv     (control_cv),
        .last_channel   (last_channel),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .channel_level  (channel_level),
        .mix_sum        (mix_sum),
        .mix_valid      (mix_valid)
    );

endmodule

@@ sv/csxfm_ctrl.sv @@
// Sequencer of the mixer core: walks one channel beat through the datapath.
// Depends on csxfm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "circular_scan_crossfade_mixer_core_macros.svh"

module csxfm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  csxfm_pkg::dp_status_t status,
    output logic                  in_stall,
    output csxfm_pkg::dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CVMUL = 8'b0000_0010,
        ST_LATCH = 8'b0000_0100,
        ST_WRAP  = 8'b0000_1000,
        ST_DIST  = 8'b0001_0000,
        ST_SCALE = 8'b0010_0000,
        ST_TERM  = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = status.first_channel ? ST_CVMUL : ST_DIST;
                end
            end
            ST_CVMUL:
            begin
                cmd.cv_mul = 1'b1;
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                cmd.latch_pos = 1'b1;
                state_next    = ST_WRAP;
            end
            ST_WRAP:
            begin
                cmd.wrap_step = 1'b1;
                if (status.wrap_done)
                begin
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                cmd.dist_calc = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    `CSXFM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall,
        "beat accepted but core not busy next cycle")

endmodule

@@ sv/csxfm_dp.sv @@
// Datapath of the mixer core: config registers, scan position, levels, frame sum.
// Depends on csxfm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "circular_scan_crossfade_mixer_core_macros.svh"

module csxfm_dp #(
    parameter int CHANNELS = csxfm_pkg::CHANNELS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [csxfm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [csxfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [15:0]                   channel_sample,
    input  logic [9:0]                           channel_gain,
    input  logic signed [12:0]                   control_cv,
    input  logic                                 last_channel,
    input  logic                                 out_stall,
    input  csxfm_pkg::dp_cmd_t                   cmd,
    output csxfm_pkg::dp_status_t                status,
    output logic                                 out_valid,
    output logic [15:0]                          channel_level,
    output logic signed [20:0]                   mix_sum,
    output logic                                 mix_valid
);

    // configuration
    logic signed [11:0] offset_reg;
    logic signed [15:0] amount_reg;
    logic [14:0]        inv_reg;
    logic               oc_reg;
    logic [11:0]        mask_reg;

    // beat payload
    logic signed [15:0] sample_reg;
    logic [9:0]         gain_reg;
    logic signed [12:0] cv_reg;
    logic               last_reg;

    // work registers
    logic signed [28:0] cvprod_reg;
    logic signed [14:0] pos_reg;
    logic [11:0]        dist_reg;
    logic               act_reg;
    logic signed [25:0] sg_reg;
    logic [15:0]        level_reg;
    logic signed [17:0] term_reg;

    // control state
    logic [12:0]        scan_reg;
    logic [12:0]        scan_next;
    logic [3:0]         cc_reg;
    logic [3:0]         cc_next;
    logic [3:0]         rank_reg;
    logic [3:0]         rank_next;
    logic signed [20:0] acc_reg;
    logic signed [20:0] acc_next;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        channel_level_reg;
    logic signed [20:0] mix_sum_reg;
    logic               mix_valid_reg;

    logic [3:0]         n_conn;
    logic [4:0]         n_active;
    logic [12:0]        span;
    logic signed [14:0] span_s;
    logic [15:0]        mask_wide;
    logic               chan_active;

    logic signed [28:0] cvprod_full;
    logic signed [13:0] cv_term;
    logic signed [14:0] pos_start;
    logic signed [14:0] pos_next;
    logic               wrap_low;
    logic               wrap_high;

    logic [11:0]        rank_base;
    logic signed [13:0] diff0;
    logic signed [13:0] diff1;
    logic signed [14:0] twice;
    logic signed [13:0] far;
    logic signed [13:0] d_raw;
    logic [11:0]        dist_next;
    logic signed [26:0] sg_full;

    logic [26:0]        scale_full;
    logic [19:0]        scaled;
    logic [15:0]        level_calc;
    logic [15:0]        level_next;

    logic signed [42:0] term_full;
    logic signed [21:0] acc_sum;
    logic signed [20:0] acc_sat;

    // active channel count
    always_comb
    begin
        n_conn = '0;
        for (int i = 0; i < csxfm_pkg::MASK_BITS; i++)
        begin
            if (i < CHANNELS && mask_reg[i])
            begin
                n_conn = n_conn + 4'd1;
            end
        end
    end

    assign n_active    = oc_reg ? {1'b0, n_conn} : 5'(CHANNELS);
    assign span        = {n_active, 8'b0};
    assign span_s      = $signed({2'b00, span});
    assign mask_wide   = {4'b0000, mask_reg};
    assign chan_active = ({1'b0, cc_reg} < 5'(CHANNELS)) && (!oc_reg || mask_wide[cc_reg]);

    // scan position and wrap
    assign cvprod_full = cv_reg * amount_reg;
    assign cv_term     = cvprod_reg[28:15];
    assign pos_start   = (span == '0) ? 15'sd0
                       : csxfm_pkg::POS_BASE + 15'(offset_reg) + 15'(cv_term);
    assign wrap_low    = (pos_reg < 15'sd0);
    assign wrap_high   = (pos_reg > span_s);

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.latch_pos)
        begin
            pos_next = pos_start;
        end
        else if (cmd.wrap_step)
        begin
            if (wrap_low)
            begin
                pos_next = pos_reg + span_s;
            end
            else if (wrap_high)
            begin
                pos_next = pos_reg - span_s;
            end
        end
    end

    // circular distance
    assign rank_base = {rank_reg, 8'b0};
    assign diff0     = $signed({1'b0, scan_reg}) - $signed({2'b00, rank_base});
    assign diff1     = (diff0 < 14'sd0) ? diff0 + $signed({1'b0, span}) : diff0;
    assign twice     = {diff1, 1'b0};
    assign far       = $signed({1'b0, span}) - diff1;
    assign d_raw     = (twice < span_s) ? diff1 : far;
    assign dist_next = (d_raw < 14'sd0) ? 12'd0 : d_raw[11:0];
    assign sg_full   = sample_reg * $signed({1'b0, gain_reg});

    // level
    assign scale_full = dist_reg * inv_reg;
    assign scaled     = scale_full[26:7];
    assign level_calc = (scaled > 20'(csxfm_pkg::LEVEL_ONE)) ? 16'd0
                      : csxfm_pkg::LEVEL_ONE - scaled[15:0];
    assign level_next = act_reg ? level_calc : 16'd0;

    // weighted term and saturating sum
    assign term_full = sg_reg * $signed({1'b0, level_reg});
    assign acc_sum   = 22'(acc_reg) + 22'(term_reg);

    always_comb
    begin
        if (acc_sum > csxfm_pkg::ACC_MAX)
        begin
            acc_sat = csxfm_pkg::ACC_MAX[20:0];
        end
        else if (acc_sum < csxfm_pkg::ACC_MIN)
        begin
            acc_sat = csxfm_pkg::ACC_MIN[20:0];
        end
        else
        begin
            acc_sat = acc_sum[20:0];
        end
    end

    always_comb
    begin
        scan_next      = scan_reg;
        cc_next        = cc_reg;
        rank_next      = rank_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.latch_pos)
        begin
            rank_next = '0;
        end
        if (cmd.wrap_step && !wrap_low && !wrap_high)
        begin
            scan_next = pos_reg[12:0];
        end
        if (cmd.scale && act_reg)
        begin
            rank_next = rank_reg + 4'd1;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (last_reg)
            begin
                acc_next  = '0;
                cc_next   = '0;
                rank_next = '0;
            end
            else
            begin
                acc_next = acc_sat;
                cc_next  = cc_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= csxfm_pkg::OFFSET_RESET;
            amount_reg    <= csxfm_pkg::AMOUNT_RESET;
            inv_reg       <= csxfm_pkg::INV_RESET;
            oc_reg        <= csxfm_pkg::OC_RESET;
            mask_reg      <= csxfm_pkg::MASK_RESET;
            scan_reg      <= '0;
            cc_reg        <= '0;
            rank_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    csxfm_pkg::REG_SELECTION_OFFSET: offset_reg <= cfg_data[11:0];
                    csxfm_pkg::REG_CV_AMOUNT:        amount_reg <= cfg_data;
                    csxfm_pkg::REG_INV_DIFFUSION:    inv_reg    <= cfg_data[14:0];
                    csxfm_pkg::REG_ONLY_CONNECTED:   oc_reg     <= cfg_data[0];
                    csxfm_pkg::REG_CONNECTED_MASK:   mask_reg   <= cfg_data[11:0];
                    default:
                    begin
                    end
                endcase
            end
            scan_reg      <= scan_next;
            cc_reg        <= cc_next;
            rank_reg      <= rank_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= channel_sample;
            gain_reg   <= channel_gain;
            cv_reg     <= control_cv;
            last_reg   <= last_channel;
        end
        if (cmd.cv_mul)
        begin
            cvprod_reg <= cvprod_full;
        end
        pos_reg <= pos_next;
        if (cmd.dist_calc)
        begin
            dist_reg <= dist_next;
            act_reg  <= chan_active && (span != '0);
            sg_reg   <= sg_full[25:0];
        end
        if (cmd.scale)
        begin
            level_reg <= level_next;
        end
        if (cmd.term)
        begin
            term_reg <= term_full[40:23];
        end
        if (cmd.emit)
        begin
            channel_level_reg <= level_reg;
            mix_sum_reg       <= last_reg ? acc_sat : 21'sd0;
            mix_valid_reg     <= last_reg;
        end
    end

    assign status.first_channel = (cc_reg == '0);
    assign status.wrap_done     = !wrap_low && !wrap_high;
    assign status.out_free      = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign channel_level = channel_level_reg;
    assign mix_sum       = mix_sum_reg;
    assign mix_valid     = mix_valid_reg;

    `CSXFM_ASSERT(a_scan_in_range, clk, rst_n, scan_reg <= csxfm_pkg::SCAN_MAX,
        "scan position beyond channel span")
    `CSXFM_ASSERT_IMP(a_level_in_range, clk, rst_n, out_valid_reg,
        channel_level_reg <= csxfm_pkg::LEVEL_ONE, "level above unity")
    `CSXFM_ASSERT_IMP(a_sum_only_on_last, clk, rst_n, out_valid_reg && !mix_valid_reg,
        mix_sum_reg == 21'sd0, "frame sum shown on a non-final beat")
    `CSXFM_ASSERT_NXT(a_emit_fills_output, clk, rst_n, cmd.emit, out_valid_reg,
        "result lost after emit")

endmodule
